// ===== hdl/gbhs_pkg.sv =====
`timescale 1ns / 1ps
package gbhs_pkg;
  localparam int MAX_COLUMNS_DEF   = 128;
  localparam int MAX_ROWS_DEF      = 128;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int HEIGHT_W = 32;
  localparam int DIM_W    = 8;
  localparam int CELL_W   = 7;
  localparam int CNT_W    = 11;  // holds any grid size up to 1024
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 32;
  // span, and offset into the span, as unsigned magnitudes
  localparam int SPAN_W   = 29;

  localparam logic [CFG_IDX_W-1:0] REG_SOUTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING = 3'd6;

  localparam logic kind_write = 1'b0;
  localparam logic kind_query = 1'b1;
endpackage

// ===== hdl/gbhs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The caller guarantees
// dividend < divisor * 2^QW, so only QW quotient bits are produced.
module gbhs_div #(
  parameter int AW = 29,
  parameter int QW = 23
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AW+QW-1:0]  dividend_i,
  input  logic [AW-1:0]     divisor_i,
  output logic              done_o,
  output logic [QW-1:0]     quotient_o
);
  localparam int CNTW = $clog2(QW + 1);

  logic [AW-1:0]   rem_q, rem_d;
  logic [AW-1:0]   div_q;
  logic [QW-1:0]   low_q, low_d;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [AW:0]     trial;
  logic            ge;

  always_comb begin
    trial = {rem_q, low_q[QW-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? AW'(trial - {1'b0, div_q}) : trial[AW-1:0];
    low_d = {low_q[QW-2:0], ge};  // quotient bits shift in behind the dividend
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[AW+QW-1:QW];
      low_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done held");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !start_i |-> rem_q < div_q) else $error("remainder not below divisor");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("divider restarted while running");
endmodule

// ===== hdl/grid_bilinear_height_sampler_top.sv =====
`timescale 1ns / 1ps
// Bilinear height sampler. A write request (kind 0) stores one cell in the
// cycle it is accepted and gives no result. A query request (kind 1) keeps
// busy high until it finishes: the two fractional coordinates come from one
// shared bit-per-cycle divider, the four corners are read one at a time from
// the grid memory, and the three interpolation steps share one multiplier.
// A query that fails a check ends early. The result is shown with done_o
// for one cycle and is not held; the receiver cannot stall it.
module grid_bilinear_height_sampler_top #(
  parameter int MAX_COLUMNS   = gbhs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = gbhs_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = gbhs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind_i,
  input  logic [gbhs_pkg::CELL_W-1:0]           cell_column_i,
  input  logic [gbhs_pkg::CELL_W-1:0]           cell_row_i,
  input  logic signed [gbhs_pkg::HEIGHT_W-1:0]  cell_height_i,
  input  logic signed [gbhs_pkg::LAT_W-1:0]     query_latitude_i,
  input  logic signed [gbhs_pkg::LON_W-1:0]     query_longitude_i,
  output logic                                  done_o,
  output logic signed [gbhs_pkg::HEIGHT_W-1:0]  sampled_height_o,
  output logic                                  sample_valid_o,
  input  logic                                  cfg_we_i,
  input  logic [gbhs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gbhs_pkg::CFG_W-1:0]            cfg_wdata_i
);
  localparam int CAW = $clog2(MAX_COLUMNS);
  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CW  = (CAW > RAW) ? CAW : RAW;
  localparam int F   = FRACTION_BITS;
  localparam int AW  = gbhs_pkg::SPAN_W;
  localparam int QW  = CW + F;
  localparam int MA  = gbhs_pkg::HEIGHT_W + 2;
  localparam int MB  = ((F > CW) ? F : CW) + 1;
  localparam int PW  = MA + MB;
  localparam int HW  = gbhs_pkg::HEIGHT_W;
  localparam int NW  = gbhs_pkg::CNT_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_MX   = 5'd2;
  localparam logic [4:0] S_WX   = 5'd3;
  localparam logic [4:0] S_DX   = 5'd4;
  localparam logic [4:0] S_DVX  = 5'd5;
  localparam logic [4:0] S_MY   = 5'd6;
  localparam logic [4:0] S_WY   = 5'd7;
  localparam logic [4:0] S_DY   = 5'd8;
  localparam logic [4:0] S_DVY  = 5'd9;
  localparam logic [4:0] S_RA   = 5'd10;
  localparam logic [4:0] S_RB   = 5'd11;
  localparam logic [4:0] S_LT   = 5'd12;
  localparam logic [4:0] S_W1   = 5'd13;
  localparam logic [4:0] S_UT   = 5'd14;
  localparam logic [4:0] S_W2   = 5'd15;
  localparam logic [4:0] S_UB   = 5'd16;
  localparam logic [4:0] S_W3   = 5'd17;
  localparam logic [4:0] S_UR   = 5'd18;

  // configuration
  logic signed [gbhs_pkg::LAT_W-1:0]  south_q, north_q;
  logic signed [gbhs_pkg::LON_W-1:0]  west_q, east_q;
  logic [gbhs_pkg::DIM_W-1:0]         cols_q, rows_q;
  logic signed [HW-1:0]               missing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      south_q   <= '0;
      north_q   <= '0;
      west_q    <= '0;
      east_q    <= '0;
      cols_q    <= '0;
      rows_q    <= '0;
      missing_q <= {1'b1, {(HW-1){1'b0}}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbhs_pkg::REG_SOUTH:   south_q   <= cfg_wdata_i[gbhs_pkg::LAT_W-1:0];
        gbhs_pkg::REG_NORTH:   north_q   <= cfg_wdata_i[gbhs_pkg::LAT_W-1:0];
        gbhs_pkg::REG_WEST:    west_q    <= cfg_wdata_i[gbhs_pkg::LON_W-1:0];
        gbhs_pkg::REG_EAST:    east_q    <= cfg_wdata_i[gbhs_pkg::LON_W-1:0];
        gbhs_pkg::REG_COLUMNS: cols_q    <= cfg_wdata_i[gbhs_pkg::DIM_W-1:0];
        gbhs_pkg::REG_ROWS:    rows_q    <= cfg_wdata_i[gbhs_pkg::DIM_W-1:0];
        gbhs_pkg::REG_MISSING: missing_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // saturated grid size
  logic [NW-1:0] ncols, nrows;
  assign ncols = (NW'(cols_q) > NW'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS) : NW'(cols_q);
  assign nrows = (NW'(rows_q) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_q);

  // sequencer and datapath registers
  logic [4:0]                         state_q, state_d;
  logic signed [gbhs_pkg::LAT_W-1:0]  lat_q;
  logic signed [gbhs_pkg::LON_W-1:0]  lon_q;
  logic signed [MA-1:0]               ma_q;
  logic signed [MB-1:0]               mb_q;
  logic signed [PW-1:0]               prod_q;
  logic [CW-1:0]                      x0_q, y0_q;
  logic [F-1:0]                       tx_q, ty_q;
  logic [1:0]                         k_q;
  logic signed [HW-1:0]               h_q [4];
  logic signed [HW-1:0]               top_q;
  logic                               done_q, valid_q;
  logic signed [HW-1:0]               res_q;

  // bounds checks
  logic signed [gbhs_pkg::LON_W:0]    londiff, lonspan;
  logic signed [gbhs_pkg::LAT_W:0]    latdiff, latspan;
  logic                               bad;
  assign londiff = (gbhs_pkg::LON_W+1)'(lon_q) - (gbhs_pkg::LON_W+1)'(west_q);
  assign lonspan = (gbhs_pkg::LON_W+1)'(east_q) - (gbhs_pkg::LON_W+1)'(west_q);
  assign latdiff = (gbhs_pkg::LAT_W+1)'(north_q) - (gbhs_pkg::LAT_W+1)'(lat_q);
  assign latspan = (gbhs_pkg::LAT_W+1)'(north_q) - (gbhs_pkg::LAT_W+1)'(south_q);
  assign bad = (ncols < NW'(2)) || (nrows < NW'(2)) ||
               (north_q <= south_q) || (east_q <= west_q) ||
               (lat_q < south_q) || (lat_q > north_q) ||
               (lon_q < west_q) || (lon_q > east_q);

  // shared divider
  logic             div_start, div_done;
  logic [AW+QW-1:0] div_dividend;
  logic [AW-1:0]    div_divisor;
  logic [QW-1:0]    quot;
  assign div_start    = (state_q == S_DX) || (state_q == S_DY);
  assign div_dividend = {prod_q[AW+CW-1:0], {F{1'b0}}};
  assign div_divisor  = (state_q == S_DX) ? AW'(lonspan) : AW'(latspan);

  gbhs_div #(.AW(AW), .QW(QW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // neighbor indexes, clamped at the last column and row
  logic [CW-1:0] x1, y1;
  assign x1 = ((NW'(x0_q) + NW'(1)) < ncols) ? x0_q + CW'(1) : x0_q;
  assign y1 = ((NW'(y0_q) + NW'(1)) < nrows) ? y0_q + CW'(1) : y0_q;

  // grid memory
  logic [HW-1:0]          mem [2**(CAW+RAW)];
  logic [HW-1:0]          rdata_q;
  logic                   mem_we;
  logic [CAW+RAW-1:0]     waddr, raddr;
  logic [CW-1:0]          rcol, rrow;
  assign mem_we = (state_q == S_IDLE) && start && (kind_i == gbhs_pkg::kind_write) &&
                  (NW'(cell_column_i) < NW'(MAX_COLUMNS)) &&
                  (NW'(cell_row_i) < NW'(MAX_ROWS));
  assign waddr  = {RAW'(cell_row_i), CAW'(cell_column_i)};
  assign rcol   = k_q[0] ? x1 : x0_q;
  assign rrow   = k_q[1] ? y1 : y0_q;
  assign raddr  = {rrow[RAW-1:0], rcol[CAW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= cell_height_i;
    rdata_q <= mem[raddr];
  end

  // lerp: a + floor(prod / 2^F)
  logic signed [PW-1:0] shifted;
  logic signed [HW-1:0] lerp_top, lerp_bot, lerp_res;
  assign shifted  = prod_q >>> F;
  assign lerp_top = HW'(PW'(h_q[0]) + shifted);
  assign lerp_bot = HW'(PW'(h_q[2]) + shifted);
  assign lerp_res = HW'(PW'(top_q) + shifted);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start && kind_i == gbhs_pkg::kind_query) state_d = S_CHK;
      S_CHK:  state_d = bad ? S_IDLE : S_MX;
      S_MX:   state_d = S_WX;
      S_WX:   state_d = S_DX;
      S_DX:   state_d = S_DVX;
      S_DVX:  if (div_done) state_d = S_MY;
      S_MY:   state_d = S_WY;
      S_WY:   state_d = S_DY;
      S_DY:   state_d = S_DVY;
      S_DVY:  if (div_done) state_d = S_RA;
      S_RA:   state_d = S_RB;
      S_RB: begin
        if (rdata_q == missing_q) state_d = S_IDLE;
        else if (k_q == 2'd3) state_d = S_LT;
        else state_d = S_RA;
      end
      S_LT:   state_d = S_W1;
      S_W1:   state_d = S_UT;
      S_UT:   state_d = S_W2;
      S_W2:   state_d = S_UB;
      S_UB:   state_d = S_W3;
      S_W3:   state_d = S_UR;
      S_UR:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
      if (state_q == S_CHK && bad) done_q <= 1'b1;
      if (state_q == S_RB && rdata_q == missing_q) done_q <= 1'b1;
      if (state_q == S_UR) begin
        done_q  <= 1'b1;
        valid_q <= 1'b1;
      end
      if (state_q == S_CHK) k_q <= '0;
      else if (state_q == S_RB) k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(ma_q) * PW'(mb_q);
    if (state_q == S_IDLE) begin
      lat_q <= query_latitude_i;
      lon_q <= query_longitude_i;
    end
    case (state_q)
      S_CHK: res_q <= '0;
      S_MX: begin
        ma_q <= MA'(londiff);
        mb_q <= MB'(ncols - NW'(1));
      end
      S_DVX: if (div_done) begin
        x0_q <= quot[QW-1:F];
        tx_q <= quot[F-1:0];
      end
      S_MY: begin
        ma_q <= MA'(latdiff);
        mb_q <= MB'(nrows - NW'(1));
      end
      S_DVY: if (div_done) begin
        y0_q <= quot[QW-1:F];
        ty_q <= quot[F-1:0];
      end
      S_RB: begin
        h_q[k_q] <= rdata_q;
        res_q    <= '0;
      end
      S_LT: begin
        ma_q <= MA'(h_q[1]) - MA'(h_q[0]);
        mb_q <= MB'(tx_q);
      end
      S_UT: begin
        top_q <= lerp_top;
        ma_q  <= MA'(h_q[3]) - MA'(h_q[2]);
        mb_q  <= MB'(tx_q);
      end
      S_UB: begin
        ma_q  <= MA'(lerp_bot) - MA'(top_q);
        mb_q  <= MB'(ty_q);
      end
      S_UR: res_q <= lerp_res;
      default: ;
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign sample_valid_o   = valid_q;
  assign sampled_height_o = res_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !sample_valid_o |-> sampled_height_o == '0)
    else $error("invalid result not zero");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i == gbhs_pkg::kind_query |=> busy)
    else $error("query request not taken");
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> done_o) else $error("valid without strobe");
endmodule
